// ----- rtl/ams_pkg.sv -----
// Shared types, constants and helper functions for the adjacency matrix store.
package ams_pkg;

    // Width used for every vertex index compare (holds up to 64 plus carry room)
    localparam int IDX_W = 7;
    // Fixed result field widths
    localparam int VC_W  = 6;
    localparam int AC_W  = 11;
    localparam int ROW_W = 32;
    // Widest row the popcount helper covers
    localparam int POP_W = 64;

    // Operation codes carried in the func field
    typedef enum logic [2:0] {
        FN_READ      = 3'd0,
        FN_SET       = 3'd1,
        FN_CLEAR     = 3'd2,
        FN_ADD       = 3'd3,
        FN_REMOVE    = 3'd4,
        FN_TRANSPOSE = 3'd5
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Sequencer to row ring control
    typedef struct packed {
        logic             start;
        logic             run;
        func_t            op;
        logic             op_ok;
        logic [IDX_W-1:0] cnt;
        logic [IDX_W-1:0] nv;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
    } ams_ctrl_t;

    // Row ring to sequencer status for the row at the head
    typedef struct packed {
        logic             flip;
        logic [IDX_W-1:0] lost_inc;
    } ams_stat_t;

    // Sequencer result status
    typedef struct packed {
        logic             done;
        logic             err;
        logic [IDX_W-1:0] dst;
        logic [VC_W-1:0]  vertex_count;
        logic [AC_W-1:0]  arc_count;
    } ams_sts_t;

    // Population count as a balanced adder tree
    function automatic logic [IDX_W-1:0] pop64(input logic [POP_W-1:0] w);
        logic [IDX_W-1:0] acc [POP_W];
        int               span;
        for (int i = 0; i < POP_W; i++) begin
            acc[i] = {{(IDX_W-1){1'b0}}, w[i]};
        end
        span = 1;
        while (span < POP_W) begin
            for (int i = 0; i < POP_W; i += 2 * span) begin
                acc[i] = acc[i] + acc[i + span];
            end
            span = span * 2;
        end
        return acc[0];
    endfunction

endpackage

// ----- rtl/ams_if.sv -----
// Request and response channel interfaces of the adjacency matrix store.
interface ams_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [4:0] from_vertex;
    logic [4:0] to_vertex;

    modport source (output valid, func, from_vertex, to_vertex, input ready);
    modport sink   (input valid, func, from_vertex, to_vertex, output ready);
endinterface

interface ams_rsp_if;
    logic        valid;
    logic        ready;
    logic        cell_bit;
    logic [31:0] row_bits;
    logic [5:0]  vertex_count;
    logic [10:0] arc_count;
    logic        error_flag;

    modport source (output valid, cell_bit, row_bits, vertex_count, arc_count, error_flag,
                    input ready);
    modport sink   (input valid, cell_bit, row_bits, vertex_count, arc_count, error_flag,
                    output ready);
endinterface

// ----- rtl/ams_row_ring.sv -----
// Circulating row store with the shared head-row processing unit.
module ams_row_ring #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ams_pkg::ams_ctrl_t      ctrl,
    output ams_pkg::ams_stat_t      stat,
    output logic [MAX_VERTICES-1:0] row_cap
);
    import ams_pkg::*;

    localparam int M  = MAX_VERTICES;
    localparam int CW = $clog2(M);

    logic [M-1:0] rows_reg [M];
    logic [M-1:0] rows_next [M];
    logic [M-1:0] work [M];
    logic [M-1:0] cap_reg, cap_next;
    logic [M-1:0] head, tail, hs, src_row;
    logic [M+POP_W-1:0] head_ext;
    logic         hit, last;

    // Bit i of a row, zero past the last column
    function automatic logic bit_of(input logic [M-1:0] r, input logic [IDX_W-1:0] i);
        return (i < IDX_W'(M)) ? r[i[CW-1:0]] : 1'b0;
    endfunction

    function automatic logic [M-1:0] one_at(input logic [IDX_W-1:0] i);
        logic [M-1:0] o;
        for (int b = 0; b < M; b++) begin
            o[b] = (IDX_W'(b) == i);
        end
        return o;
    endfunction

    // Remove column c, higher columns move down one place
    function automatic logic [M-1:0] drop_col(input logic [M-1:0] r,
                                              input logic [IDX_W-1:0] c);
        logic [M-1:0] o;
        for (int b = 0; b < M - 1; b++) begin
            o[b] = (IDX_W'(b) < c) ? r[b] : r[b + 1];
        end
        o[M-1] = (IDX_W'(M - 1) < c) ? r[M-1] : 1'b0;
        return o;
    endfunction

    function automatic logic [M-1:0] rotr1(input logic [M-1:0] r);
        return {r[0], r[M-1:1]};
    endfunction

    assign head     = rows_reg[0];
    assign hit      = (ctrl.cnt == ctrl.src);
    assign last     = (ctrl.cnt == IDX_W'(M - 1));
    assign head_ext = {{POP_W{1'b0}}, head};

    // Per-row status for the arc bookkeeping
    always_comb
    begin
        stat.flip     = bit_of(head, ctrl.dst) != (ctrl.op == FN_SET);
        stat.lost_inc = hit ? pop64(head_ext[POP_W-1:0])
                            : {{(IDX_W-1){1'b0}}, bit_of(head, ctrl.src)};
    end

    // Transpose swap: head row against column cnt of the rows still unvisited
    always_comb
    begin
        work = rows_reg;
        hs   = head;
        for (int p = 1; p < M; p++) begin
            if ((IDX_W'(p) + ctrl.cnt) < IDX_W'(M)) begin
                hs[p]      = rows_reg[p][0];
                work[p][0] = head[p];
            end
        end
    end

    // Head-row processing: value written back at the tail
    always_comb
    begin
        src_row = (ctrl.cnt >= ctrl.src) ? (last ? '0 : rows_reg[1]) : head;
        tail    = head;
        unique case (ctrl.op)
            FN_SET:
            begin
                if (ctrl.op_ok && hit)
                    tail = head | one_at(ctrl.dst);
            end
            FN_CLEAR:
            begin
                if (ctrl.op_ok && hit)
                    tail = head & ~one_at(ctrl.dst);
            end
            FN_ADD:
            begin
                if (ctrl.op_ok)
                    tail = (ctrl.cnt == ctrl.nv) ? '0 : (head & ~one_at(ctrl.nv));
            end
            FN_REMOVE:
            begin
                if (ctrl.op_ok)
                    tail = drop_col(src_row, ctrl.src);
            end
            FN_TRANSPOSE:
            begin
                tail = rotr1(hs);
            end
            default:
            begin
                tail = head;
            end
        endcase
    end

    // Ring shift and row capture
    always_comb
    begin
        rows_next = rows_reg;
        cap_next  = cap_reg;
        if (ctrl.start)
        begin
            cap_next = '0;
        end
        else if (ctrl.run)
        begin
            for (int p = 0; p < M - 1; p++) begin
                rows_next[p] = (ctrl.op == FN_TRANSPOSE) ? rotr1(work[p + 1])
                                                         : rows_reg[p + 1];
            end
            rows_next[M-1] = tail;
            if (hit)
                cap_next = tail;
            else if (ctrl.op == FN_TRANSPOSE)
                cap_next = rotr1(cap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < M; p++) begin
                rows_reg[p] <= '0;
            end
            cap_reg <= '0;
        end
        else
        begin
            rows_reg <= rows_next;
            cap_reg  <= cap_next;
        end
    end

    assign row_cap = cap_reg;

endmodule

// ----- rtl/ams_seq.sv -----
// Sequencer: request decode, pass counter, vertex and arc counts.
module ams_seq #(
    parameter int MAX_VERTICES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    ams_req_if.sink            req,
    input  logic               rsp_ready,
    input  ams_pkg::ams_stat_t stat,
    output ams_pkg::ams_ctrl_t ctrl,
    output ams_pkg::ams_sts_t  sts
);
    import ams_pkg::*;

    localparam int M  = MAX_VERTICES;
    localparam int CW = $clog2(M);
    localparam int VW = $clog2(M + 1);
    localparam int AW = $clog2(M * M + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    func_t         op_reg, op_next;
    logic          ok_reg, ok_next;
    logic          err_reg, err_next;
    logic [4:0]    src_reg, src_next;
    logic [4:0]    dst_reg, dst_next;
    logic [VW-1:0] nv_reg, nv_next;
    logic [AW-1:0] arcs_reg, arcs_next;
    logic [AW-1:0] lost_reg, lost_next;
    logic [AW-1:0] lost_sum;

    logic          accept, run, done, last, hit, in_range;
    func_t         dec_op;
    logic          dec_ok, dec_err;

    assign accept   = req.valid && req.ready;
    assign last     = (cnt_reg == CW'(M - 1));
    assign hit      = (IDX_W'(cnt_reg) == IDX_W'(src_reg));
    assign in_range = (IDX_W'(req.from_vertex) < IDX_W'(nv_reg)) &&
                      (IDX_W'(req.to_vertex) < IDX_W'(nv_reg));

    // Request decode against the current vertex count
    always_comb
    begin
        dec_op  = FN_READ;
        dec_ok  = 1'b0;
        dec_err = 1'b0;
        unique case (func_t'(req.func)) inside
            FN_READ:
            begin
                dec_err = !in_range;
            end
            FN_SET, FN_CLEAR:
            begin
                dec_op  = func_t'(req.func);
                dec_ok  = in_range;
                dec_err = !in_range;
            end
            FN_ADD:
            begin
                dec_op  = FN_ADD;
                dec_ok  = IDX_W'(nv_reg) < IDX_W'(M);
                dec_err = !(IDX_W'(nv_reg) < IDX_W'(M));
            end
            FN_REMOVE:
            begin
                dec_op  = FN_REMOVE;
                dec_ok  = IDX_W'(req.from_vertex) < IDX_W'(nv_reg);
                dec_err = !(IDX_W'(req.from_vertex) < IDX_W'(nv_reg));
            end
            FN_TRANSPOSE:
            begin
                dec_op  = FN_TRANSPOSE;
                dec_ok  = 1'b1;
            end
            default:
            begin
                dec_err = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req.ready = 1'b0;
        run       = 1'b0;
        done      = 1'b0;
        unique case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_RUN:  run       = 1'b1;
            ST_DONE: done      = 1'b1;
            default: req.ready = 1'b0;
        endcase
    end

    // Item registers, pass counter and count updates
    always_comb
    begin
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        ok_next   = ok_reg;
        err_next  = err_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        nv_next   = nv_reg;
        arcs_next = arcs_reg;
        lost_next = lost_reg;
        lost_sum  = lost_reg + AW'(stat.lost_inc);
        if (accept)
        begin
            op_next   = dec_op;
            ok_next   = dec_ok;
            err_next  = dec_err;
            src_next  = req.from_vertex;
            dst_next  = req.to_vertex;
            cnt_next  = '0;
            lost_next = '0;
        end
        else if (run)
        begin
            cnt_next = last ? '0 : cnt_reg + CW'(1);
            if (ok_reg)
            begin
                unique case (op_reg)
                    FN_SET:
                    begin
                        if (hit && stat.flip)
                            arcs_next = arcs_reg + AW'(1);
                    end
                    FN_CLEAR:
                    begin
                        if (hit && stat.flip)
                            arcs_next = arcs_reg - AW'(1);
                    end
                    FN_ADD:
                    begin
                        if (last)
                            nv_next = nv_reg + VW'(1);
                    end
                    FN_REMOVE:
                    begin
                        lost_next = lost_sum;
                        if (last)
                        begin
                            arcs_next = arcs_reg - lost_sum;
                            nv_next   = nv_reg - VW'(1);
                        end
                    end
                    default:
                    begin
                        nv_next = nv_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= FN_READ;
            ok_reg    <= 1'b0;
            err_reg   <= 1'b0;
            src_reg   <= '0;
            dst_reg   <= '0;
            nv_reg    <= '0;
            arcs_reg  <= '0;
            lost_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            ok_reg    <= ok_next;
            err_reg   <= err_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            nv_reg    <= nv_next;
            arcs_reg  <= arcs_next;
            lost_reg  <= lost_next;
        end
    end

    // Control toward the row ring
    always_comb
    begin
        ctrl.start = accept;
        ctrl.run   = run;
        ctrl.op    = op_reg;
        ctrl.op_ok = ok_reg;
        ctrl.cnt   = IDX_W'(cnt_reg);
        ctrl.nv    = IDX_W'(nv_reg);
        ctrl.src   = IDX_W'(src_reg);
        ctrl.dst   = IDX_W'(dst_reg);
    end

    // Status toward the top level
    always_comb
    begin
        sts.done         = done;
        sts.err          = err_reg;
        sts.dst          = IDX_W'(dst_reg);
        sts.vertex_count = VC_W'(nv_reg);
        sts.arc_count    = AC_W'(arcs_reg);
    end

endmodule

// ----- rtl/adjacency_matrix_store.sv -----
// Adjacency matrix store: directed graph bit matrix with vertex and arc counts.
// Each request is accepted, then makes one ring pass over all MAX_VERTICES rows
// through the head-row unit, then the response is given.
// The response is valid from the cycle after the pass and holds until taken.
// Reset (rst_n low, asynchronous) clears the matrix and both counts.
module adjacency_matrix_store #(
    parameter int MAX_VERTICES = 32
) (
    input logic       clk,
    input logic       rst_n,
    ams_req_if.sink   req,
    ams_rsp_if.source rsp
);
    import ams_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES);

    ams_ctrl_t                 ctrl;
    ams_stat_t                 stat;
    ams_sts_t                  sts;
    logic [MAX_VERTICES-1:0]   row_cap;

    ams_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl),
        .sts       (sts)
    );

    ams_row_ring #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .row_cap (row_cap)
    );

    // Response fields; rows and columns past the vertex count are kept zero
    assign rsp.valid        = sts.done;
    assign rsp.row_bits     = ROW_W'(row_cap);
    assign rsp.cell_bit     = (sts.dst < IDX_W'(MAX_VERTICES)) ? row_cap[sts.dst[CW-1:0]]
                                                              : 1'b0;
    assign rsp.vertex_count = sts.vertex_count;
    assign rsp.arc_count    = sts.arc_count;
    assign rsp.error_flag   = sts.err;

endmodule
